// File: rtl/core/sstv_pkg.sv
`timescale 1ns / 1ps

package sstv_pkg;

   // sizes
   localparam int MAX_LEVELS    = 8;
   localparam int COORD_BITS    = 16;
   localparam int INDEX_BITS    = 13;
   localparam int LEVEL_BITS    = 4;
   localparam int DEPTH_BITS    = $clog2(MAX_LEVELS + 1);
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int REQ_DATA_BITS = ((INDEX_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((6 * COORD_BITS + 7) / 8) * 8;

   // corner reset values, Q2.14
   localparam logic signed [COORD_BITS-1:0] RESET_A_X = -COORD_BITS'(8192);
   localparam logic signed [COORD_BITS-1:0] RESET_A_Y = -COORD_BITS'(8192);
   localparam logic signed [COORD_BITS-1:0] RESET_B_X = COORD_BITS'(8192);
   localparam logic signed [COORD_BITS-1:0] RESET_B_Y = -COORD_BITS'(8192);
   localparam logic signed [COORD_BITS-1:0] RESET_C_X = COORD_BITS'(0);
   localparam logic signed [COORD_BITS-1:0] RESET_C_Y = COORD_BITS'(8192);
   localparam logic [LEVEL_BITS-1:0]        RESET_LEVELS = LEVEL_BITS'(4);

   // register indexes
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_A_X    = 3'd0,
      CSR_A_Y    = 3'd1,
      CSR_B_X    = 3'd2,
      CSR_B_Y    = 3'd3,
      CSR_C_X    = 3'd4,
      CSR_C_Y    = 3'd5,
      CSR_LEVELS = 3'd6
   } csr_addr_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] x;
   } pt_type;

   typedef struct packed {
      pt_type c;
      pt_type b;
      pt_type a;
   } vtx_type;

   // item moving down the level pipeline
   typedef struct packed {
      vtx_type                 vtx;
      logic [INDEX_BITS-1:0]   rem;
      logic                    err;
   } item_type;

   // configuration seen by the datapath
   typedef struct packed {
      vtx_type                 corners;
      logic [DEPTH_BITS-1:0]   depth;
   } cfg_type;

   // powers of three, 3^0 .. 3^MAX_LEVELS
   typedef logic [31:0] pow3_tbl_type [MAX_LEVELS+1];

   function automatic pow3_tbl_type make_pow3();
      pow3_tbl_type t;
      t[0] = 32'd1;
      for (int i = 1; i <= MAX_LEVELS; i++) begin
         t[i] = t[i-1] * 32'd3;
      end
      return t;
   endfunction

   localparam pow3_tbl_type POW3_TBL = make_pow3();

   // floor((p + q) / 2), formed one bit wider so it never overflows
   function automatic logic signed [COORD_BITS-1:0] midpoint(
      input logic signed [COORD_BITS-1:0] p,
      input logic signed [COORD_BITS-1:0] q
   );
      logic signed [COORD_BITS:0] s;
      s = {p[COORD_BITS-1], p} + {q[COORD_BITS-1], q};
      return s[COORD_BITS:1];
   endfunction

   function automatic pt_type mid_pt(input pt_type p, input pt_type q);
      pt_type r;
      r.x = midpoint(p.x, q.x);
      r.y = midpoint(p.y, q.y);
      return r;
   endfunction

endpackage

// File: rtl/core/sierpinski_subtriangle_vertices_top.sv
`timescale 1ns / 1ps

// Sierpinski leaf-triangle vertex generator. Each item on req carries a leaf
// number; its base-3 digits, most significant first, pick one of the three
// corner sub-triangles at each subdivision level, and rsp returns the leaf's
// three vertices in Q2.14 with floor-rounded midpoints. A leaf number of
// 3^levels or more returns zero vertices with the error flag in rsp_tuser.
// The block takes one item per clock while rsp is not stalled. It has an
// input register with the range check, one pipeline stage per subdivision
// level, and an output register. Backpressure on rsp stalls the pipeline
// stage by stage, so bubbles are squeezed out. The user must write corners and
// levels through the csr port only while no item is in flight; not enforced.
module sierpinski_subtriangle_vertices_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: leaf_index
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [sstv_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // rsp_tdata: out_a_x, out_a_y, out_b_x, out_b_y, out_c_x, out_c_y
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sstv_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // rsp_tuser: index_too_large
   output logic [0:0]                            rsp_tuser,
   input  logic                                  csr_wr_en,
   input  logic [sstv_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  logic [sstv_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import sstv_pkg::*;

   cfg_type               cfg;
   logic [INDEX_BITS-1:0] req_idx;
   logic                  in_valid_ff;
   item_type              in_item_ff;
   item_type              in_item_in;
   logic                  lnk_valid [MAX_LEVELS+1];
   logic                  lnk_ready [MAX_LEVELS+1];
   item_type              lnk_item  [MAX_LEVELS+1];
   logic                  out_ready;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_in;
   logic                  rsp_err_ff;

   sstv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input register: range check and outer corners
   assign req_idx = req_tdata[INDEX_BITS-1:0];

   always_comb begin
      in_item_in.vtx = cfg.corners;
      in_item_in.rem = req_idx;
      in_item_in.err = {{(32-INDEX_BITS){1'b0}}, req_idx} >= POW3_TBL[cfg.depth];
   end

   assign req_tready = !in_valid_ff || lnk_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= in_item_in;
      end
   end

   assign lnk_valid[0] = in_valid_ff;
   assign lnk_item[0]  = in_item_ff;

   // one stage per level, top digit first
   for (genvar s = 0; s < MAX_LEVELS; s++) begin : g_level
      sstv_level_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_pos (DEPTH_BITS'(MAX_LEVELS - 1 - s)),
         .depth     (cfg.depth),
         .in_valid  (lnk_valid[s]),
         .in_ready  (lnk_ready[s]),
         .in_item   (lnk_item[s]),
         .out_valid (lnk_valid[s+1]),
         .out_ready (lnk_ready[s+1]),
         .out_item  (lnk_item[s+1])
      );
   end

   // output register, vertices forced to zero on a range error
   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign lnk_ready[MAX_LEVELS] = out_ready;

   always_comb begin
      if (lnk_item[MAX_LEVELS].err) begin
         rsp_data_in = '0;
      end else begin
         rsp_data_in = RSP_DATA_BITS'({lnk_item[MAX_LEVELS].vtx.c.y,
                                       lnk_item[MAX_LEVELS].vtx.c.x,
                                       lnk_item[MAX_LEVELS].vtx.b.y,
                                       lnk_item[MAX_LEVELS].vtx.b.x,
                                       lnk_item[MAX_LEVELS].vtx.a.y,
                                       lnk_item[MAX_LEVELS].vtx.a.x});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= lnk_valid[MAX_LEVELS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && lnk_valid[MAX_LEVELS]) begin
         rsp_data_ff <= rsp_data_in;
         rsp_err_ff  <= lnk_item[MAX_LEVELS].err;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_err_ff;

`ifndef SYNTHESIS
   // an error item carries zero vertices
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("range error item with nonzero vertices");

   // input stalls only when the whole pipeline is full behind a stalled output
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled with room in the pipeline");

   // the last level stage only stalls when the output register is held
   assert property (@(posedge clock) disable iff (reset)
      !lnk_ready[MAX_LEVELS] |-> rsp_valid_ff && !rsp_tready)
      else $error("level pipeline stalled without output backpressure");
`endif

endmodule

// File: rtl/core/sstv_csr.sv
`timescale 1ns / 1ps

module sstv_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [sstv_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  logic [sstv_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output sstv_pkg::cfg_type                     cfg
);
   import sstv_pkg::*;

   vtx_type               corners_ff;
   logic [DEPTH_BITS-1:0] depth_ff;
   logic [LEVEL_BITS-1:0] lvl_wr;
   logic [DEPTH_BITS-1:0] depth_in;

   // levels above the maximum act as the maximum
   assign lvl_wr   = csr_wdata[LEVEL_BITS-1:0];
   assign depth_in = (32'(lvl_wr) > MAX_LEVELS) ? DEPTH_BITS'(MAX_LEVELS)
                                                 : DEPTH_BITS'(lvl_wr);

   // register file, writes to unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         corners_ff.a.x <= RESET_A_X;
         corners_ff.a.y <= RESET_A_Y;
         corners_ff.b.x <= RESET_B_X;
         corners_ff.b.y <= RESET_B_Y;
         corners_ff.c.x <= RESET_C_X;
         corners_ff.c.y <= RESET_C_Y;
         depth_ff       <= DEPTH_BITS'(RESET_LEVELS);
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_A_X:    corners_ff.a.x <= COORD_BITS'(csr_wdata);
            CSR_A_Y:    corners_ff.a.y <= COORD_BITS'(csr_wdata);
            CSR_B_X:    corners_ff.b.x <= COORD_BITS'(csr_wdata);
            CSR_B_Y:    corners_ff.b.y <= COORD_BITS'(csr_wdata);
            CSR_C_X:    corners_ff.c.x <= COORD_BITS'(csr_wdata);
            CSR_C_Y:    corners_ff.c.y <= COORD_BITS'(csr_wdata);
            CSR_LEVELS: depth_ff       <= depth_in;
            default: begin
            end
         endcase
      end
   end

   assign cfg.corners = corners_ff;
   assign cfg.depth   = depth_ff;

endmodule

// File: rtl/core/sstv_level_stage.sv
`timescale 1ns / 1ps

module sstv_level_stage (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [sstv_pkg::DEPTH_BITS-1:0]    stage_pos,
   input  logic [sstv_pkg::DEPTH_BITS-1:0]    depth,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  sstv_pkg::item_type                 in_item,
   output logic                               out_valid,
   input  logic                               out_ready,
   output sstv_pkg::item_type                 out_item
);
   import sstv_pkg::*;

   logic       valid_ff;
   item_type   item_ff;
   item_type   item_in;
   logic [31:0] rem_w;
   logic [31:0] weight;
   logic        active;
   pt_type      ab;
   pt_type      ac;
   pt_type      bc;

   // digit weight of this level, level is skipped above the depth in use
   assign weight = POW3_TBL[stage_pos];
   assign active = stage_pos < depth;
   assign rem_w  = {{(32-INDEX_BITS){1'b0}}, in_item.rem};

   assign ab = mid_pt(in_item.vtx.a, in_item.vtx.b);
   assign ac = mid_pt(in_item.vtx.a, in_item.vtx.c);
   assign bc = mid_pt(in_item.vtx.b, in_item.vtx.c);

   // strip the top digit and keep one of the three corner triangles
   always_comb begin
      item_in = in_item;
      if (active && !in_item.err) begin
         priority if (rem_w >= (weight << 1)) begin
            item_in.rem   = INDEX_BITS'(rem_w - (weight << 1));
            item_in.vtx.a = ac;
            item_in.vtx.b = bc;
         end else if (rem_w >= weight) begin
            item_in.rem   = INDEX_BITS'(rem_w - weight);
            item_in.vtx.a = ab;
            item_in.vtx.c = bc;
         end else begin
            item_in.vtx.b = ab;
            item_in.vtx.c = ac;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: test/sstv_leaf_checker.sv
`timescale 1ns / 1ps

module sstv_leaf_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   input  logic [sstv_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [sstv_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   input  logic [0:0]                            rsp_tuser,
   input  logic                                  csr_wr_en,
   input  logic [sstv_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  logic [sstv_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output int                                    fail_count,
   output int                                    pending,
   output int                                    result_count,
   output int                                    range_err_count
);
   import sstv_pkg::*;

   // which corner a base-3 digit keeps
   localparam int KEEP_A = 0;
   localparam int KEEP_B = 1;
   localparam int KEEP_C = 2;

   typedef struct {
      logic [INDEX_BITS-1:0] leaf;
      vtx_type               vtx;
      logic                  too_large;
   } leaf_vertices_type;

   // shadow copy of the csr registers
   vtx_type               corners_q;
   logic [LEVEL_BITS-1:0] levels_q;

   leaf_vertices_type leaf_vertices_q[$];

   // floor((p + q) / 2) at full width
   function automatic logic signed [COORD_BITS-1:0] floor_half(
      input logic signed [COORD_BITS-1:0] p,
      input logic signed [COORD_BITS-1:0] q
   );
      logic signed [COORD_BITS:0] sum;
      sum = {p[COORD_BITS-1], p} + {q[COORD_BITS-1], q};
      return sum[COORD_BITS:1];
   endfunction

   function automatic pt_type half_way(input pt_type p, input pt_type q);
      pt_type r;
      r.x = floor_half(p.x, q.x);
      r.y = floor_half(p.y, q.y);
      return r;
   endfunction

   // walk the base-3 digits from the top level down to the leaf
   function automatic leaf_vertices_type leaf_vertices(input logic [INDEX_BITS-1:0] leaf);
      leaf_vertices_type r;
      int unsigned depth;
      int unsigned span;
      int unsigned place;
      int unsigned digit;
      pt_type a, b, c, ab, ac, bc;
      r.leaf      = leaf;
      r.vtx       = '0;
      r.too_large = 1'b0;
      depth = (levels_q > MAX_LEVELS) ? MAX_LEVELS : levels_q;
      span  = 1;
      for (int k = 0; k < depth; k++) begin
         span = span * 3;
      end
      if (leaf >= span) begin
         r.too_large = 1'b1;
         return r;
      end
      a = corners_q.a;
      b = corners_q.b;
      c = corners_q.c;
      place = span;
      for (int k = 0; k < depth; k++) begin
         place = place / 3;
         digit = (leaf / place) % 3;
         ab = half_way(a, b);
         ac = half_way(a, c);
         bc = half_way(b, c);
         case (digit)
            KEEP_A: begin
               b = ab;
               c = ac;
            end
            KEEP_B: begin
               a = ab;
               c = bc;
            end
            default: begin
               a = ac;
               b = bc;
            end
         endcase
      end
      r.vtx.a = a;
      r.vtx.b = b;
      r.vtx.c = c;
      return r;
   endfunction

   // watch csr, req and rsp at every rising edge
   always @(posedge clock) begin : watch
      leaf_vertices_type want;
      vtx_type           got;
      logic              got_err;
      if (reset) begin
         corners_q.a.x  <= RESET_A_X;
         corners_q.a.y  <= RESET_A_Y;
         corners_q.b.x  <= RESET_B_X;
         corners_q.b.y  <= RESET_B_Y;
         corners_q.c.x  <= RESET_C_X;
         corners_q.c.y  <= RESET_C_Y;
         levels_q       <= RESET_LEVELS;
         leaf_vertices_q.delete();
         fail_count      <= 0;
         result_count    <= 0;
         range_err_count <= 0;
         pending         <= 0;
      end else begin
         // accepted leaf index: predict its vertices
         if (req_tvalid && req_tready) begin
            leaf_vertices_q.insert(leaf_vertices_q.size(),
                                   leaf_vertices(req_tdata[INDEX_BITS-1:0]));
         end
         // accepted result: compare with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got     = vtx_type'(rsp_tdata[6*COORD_BITS-1:0]);
            got_err = rsp_tuser[0];
            result_count <= result_count + 1;
            if (got_err) begin
               range_err_count <= range_err_count + 1;
            end
            if (leaf_vertices_q.size() == 0) begin
               if (fail_count < 10) begin
                  $display("%0t: result with nothing expected: %s(%0d,%0d) b=(%0d,%0d) %s",
                           $time, "a=", got.a.x, got.a.y, got.b.x, got.b.y,
                           $sformatf("c=(%0d,%0d) err=%0b", got.c.x, got.c.y, got_err));
               end
               fail_count <= fail_count + 1;
            end else begin
               want = leaf_vertices_q.pop_front();
               if (got.a.x !== want.vtx.a.x || got.a.y !== want.vtx.a.y ||
                   got.b.x !== want.vtx.b.x || got.b.y !== want.vtx.b.y ||
                   got.c.x !== want.vtx.c.x || got.c.y !== want.vtx.c.y ||
                   got_err !== want.too_large) begin
                  if (fail_count < 10) begin
                     $display("%0t: leaf %0d expected a=(%0d,%0d) b=(%0d,%0d) %s",
                              $time, want.leaf, want.vtx.a.x, want.vtx.a.y,
                              want.vtx.b.x, want.vtx.b.y,
                              $sformatf("c=(%0d,%0d) err=%0b", want.vtx.c.x,
                                        want.vtx.c.y, want.too_large));
                     $display("%0t: leaf %0d got      a=(%0d,%0d) b=(%0d,%0d) %s",
                              $time, want.leaf, got.a.x, got.a.y, got.b.x, got.b.y,
                              $sformatf("c=(%0d,%0d) err=%0b", got.c.x, got.c.y,
                                        got_err));
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= leaf_vertices_q.size();
         // register writes, unknown indexes are dropped
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_A_X:    corners_q.a.x <= csr_wdata;
               CSR_A_Y:    corners_q.a.y <= csr_wdata;
               CSR_B_X:    corners_q.b.x <= csr_wdata;
               CSR_B_Y:    corners_q.b.y <= csr_wdata;
               CSR_C_X:    corners_q.c.x <= csr_wdata;
               CSR_C_Y:    corners_q.c.y <= csr_wdata;
               CSR_LEVELS: levels_q      <= csr_wdata[LEVEL_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// File: test/sierpinski_subtriangle_vertices_top_tb.sv
`timescale 1ns / 1ps

module sierpinski_subtriangle_vertices_top_tb;
   import sstv_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_UNUSED = 3'd7;
   localparam int IDLE_PCT    = 28;
   localparam int HOLD_CYCLES = 80;
   localparam int SETTLE      = MAX_LEVELS + 6;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic [0:0]                rsp_tuser;
   logic                      csr_wr_en;
   logic [CSR_ADDR_BITS-1:0]  csr_addr;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   int fail_count;
   int pending;
   int result_count;
   int range_err_count;

   int idle_pct;
   int hold_req_count;
   int hold_done_count;
   int settings_count;
   int leaf_span;

   sierpinski_subtriangle_vertices_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   sstv_leaf_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_wr_en       (csr_wr_en),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .result_count    (result_count),
      .range_err_count (range_err_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #2000000;
      $display("FAIL sierpinski_subtriangle_vertices_top");
      $finish;
   end

   // result side: random stalls plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_done_count != hold_req_count) begin
            hold_done_count = hold_req_count;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // offer one leaf index, with a random gap ahead of it
   task automatic send_leaf(input int unsigned leaf);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'(leaf[INDEX_BITS-1:0]);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // let every item come out before touching the registers
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // write all seven registers, optionally one unknown index as well
   task automatic program_settings(input pt_type a, input pt_type b, input pt_type c,
                                   input logic [LEVEL_BITS-1:0] lv, input bit poke_unused);
      logic [CSR_DATA_BITS-1:0] word [CSR_LEVELS+1];
      int unsigned depth;
      word[CSR_A_X]    = a.x;
      word[CSR_A_Y]    = a.y;
      word[CSR_B_X]    = b.x;
      word[CSR_B_Y]    = b.y;
      word[CSR_C_X]    = c.x;
      word[CSR_C_Y]    = c.y;
      word[CSR_LEVELS] = {(CSR_DATA_BITS-LEVEL_BITS)'($urandom), lv};
      for (int i = CSR_A_X; i <= CSR_LEVELS; i++) begin
         csr_wr_en <= 1'b1;
         csr_addr  <= CSR_ADDR_BITS'(i);
         csr_wdata <= word[i];
         @(negedge clock);
      end
      if (poke_unused) begin
         csr_addr  <= CSR_UNUSED;
         csr_wdata <= CSR_DATA_BITS'($urandom);
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
      depth = (lv > MAX_LEVELS) ? MAX_LEVELS : lv;
      leaf_span = 1;
      for (int k = 0; k < depth; k++) begin
         leaf_span = leaf_span * 3;
      end
      settings_count++;
   endtask

   function automatic pt_type any_pt();
      return pt_type'({COORD_BITS'($urandom), COORD_BITS'($urandom)});
   endfunction

   function automatic pt_type pt(input int x, input int y);
      pt_type r;
      r.x = COORD_BITS'(x);
      r.y = COORD_BITS'(y);
      return r;
   endfunction

   // mostly leaves in range, the rest anywhere in the index field
   task automatic send_random_leaves(input int count, input bit with_hold);
      for (int n = 0; n < count; n++) begin
         if (with_hold && n == count / 2) begin
            hold_req_count++;
         end
         if ($urandom_range(99) < 85) begin
            send_leaf($urandom_range(leaf_span - 1));
         end else begin
            send_leaf($urandom_range((1 << INDEX_BITS) - 1));
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_wr_en    = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      idle_pct     = IDLE_PCT;
      settings_count = 1;
      leaf_span    = 81;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset corners, four levels
      send_leaf(0);
      send_leaf(80);
      send_leaf(81);
      send_leaf(4096);
      send_leaf((1 << INDEX_BITS) - 1);
      send_random_leaves(120, 1'b0);
      drain();

      // full depth, corners at the extremes of the coordinate range
      program_settings(pt(-32768, -32768), pt(32767, -32768), pt(32767, 32767),
                       MAX_LEVELS, 1'b0);
      send_leaf(0);
      send_leaf(6560);
      send_leaf(6561);
      send_leaf(3280);
      send_leaf(2186);
      send_leaf(4374);
      send_random_leaves(320, 1'b0);
      drain();

      // zero levels: only leaf 0 exists
      program_settings(any_pt(), any_pt(), any_pt(), 4'd0, 1'b0);
      send_leaf(0);
      send_leaf(1);
      send_leaf((1 << INDEX_BITS) - 1);
      send_random_leaves(40, 1'b0);
      drain();

      // levels above the maximum, unknown register, no idling, long hold-off
      program_settings(pt(32767, 32767), pt(-32768, 32767), pt(0, -32768), 4'd15, 1'b1);
      idle_pct = 0;
      send_leaf(6560);
      send_leaf(6561);
      send_leaf(0);
      send_random_leaves(250, 1'b1);
      drain();
      idle_pct = IDLE_PCT;

      // the remaining depths with random corners
      for (int lv = 1; lv < MAX_LEVELS; lv++) begin
         program_settings(any_pt(), any_pt(), any_pt(), LEVEL_BITS'(lv), 1'b0);
         send_random_leaves(100, 1'b0);
         drain();
      end

      $display("checked %0d leaf results over %0d corner and depth settings",
               result_count, settings_count);
      $display("%0d of them flagged out of range, including depths 0 and 15",
               range_err_count);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS sierpinski_subtriangle_vertices_top");
      end else begin
         $display("FAIL sierpinski_subtriangle_vertices_top");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/sstv_pkg.sv
rtl/core/sstv_csr.sv
rtl/core/sstv_level_stage.sv
rtl/core/sierpinski_subtriangle_vertices_top.sv
test/sstv_leaf_checker.sv
test/sierpinski_subtriangle_vertices_top_tb.sv
